@@ src/sswf_pkg.sv @@
// sswf_pkg: shared constants for the servo sync-write framer
// packet layout, fixed header bytes and field widths
// no dependencies
`default_nettype none

package sswf_pkg;

    // field widths
    localparam int POS_W   = 12;
    localparam int SPEED_W = 11;
    localparam int ID_W    = 8;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 5;

    // fixed packet bytes
    localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] BCAST_ID     = 8'hFE;
    localparam logic [BYTE_W-1:0] LENGTH_FIELD = 8'h0E;
    localparam logic [BYTE_W-1:0] INSTR_SYNC_W = 8'h83;
    localparam logic [BYTE_W-1:0] START_ADDR   = 8'h1E;
    localparam logic [BYTE_W-1:0] DATA_LEN     = 8'h04;

    // byte positions within the packet
    localparam logic [IDX_W-1:0] BYTE_HDR0       = 5'd0;
    localparam logic [IDX_W-1:0] BYTE_HDR1       = 5'd1;
    localparam logic [IDX_W-1:0] BYTE_BCAST      = 5'd2;
    localparam logic [IDX_W-1:0] BYTE_LENGTH     = 5'd3;
    localparam logic [IDX_W-1:0] BYTE_INSTR      = 5'd4;
    localparam logic [IDX_W-1:0] BYTE_ADDR       = 5'd5;
    localparam logic [IDX_W-1:0] BYTE_DLEN       = 5'd6;
    localparam logic [IDX_W-1:0] BYTE_VERT_ID    = 5'd7;
    localparam logic [IDX_W-1:0] BYTE_VERT_LO    = 5'd8;
    localparam logic [IDX_W-1:0] BYTE_VERT_HI    = 5'd9;
    localparam logic [IDX_W-1:0] BYTE_VERT_SPDLO = 5'd10;
    localparam logic [IDX_W-1:0] BYTE_VERT_SPDHI = 5'd11;
    localparam logic [IDX_W-1:0] BYTE_HORZ_ID    = 5'd12;
    localparam logic [IDX_W-1:0] BYTE_HORZ_LO    = 5'd13;
    localparam logic [IDX_W-1:0] BYTE_HORZ_HI    = 5'd14;
    localparam logic [IDX_W-1:0] BYTE_HORZ_SPDLO = 5'd15;
    localparam logic [IDX_W-1:0] BYTE_HORZ_SPDHI = 5'd16;
    localparam logic [IDX_W-1:0] BYTE_CHECKSUM   = 5'd17;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MOVE_SPEED = 2'd0;
    localparam logic [1:0] REG_VERT_ID    = 2'd1;
    localparam logic [1:0] REG_HORZ_ID    = 2'd2;

    // register reset values
    localparam logic [SPEED_W-1:0] SPEED_RESET   = 11'd200;
    localparam logic [ID_W-1:0]    VERT_ID_RESET = 8'd1;
    localparam logic [ID_W-1:0]    HORZ_ID_RESET = 8'd2;

endpackage

`default_nettype wire

@@ src/servo_sync_write_framer_unit.sv @@
// servo_sync_write_framer_unit: frames a pair of goal positions into an
// 18-byte broadcast sync-write packet, one byte per output transfer
// depends on sswf_pkg
`default_nettype none

// Each input transfer carries a horizontal and a vertical goal position and
// produces 18 output transfers: FF FF FE 0E 83 1E 04, then vertical ID,
// position low/high, speed low/high, the same five for the horizontal servo,
// and the inverted 8-bit sum of bytes 2..16 flagged with tlast. One byte
// leaves per cycle from the output register while m_tready holds; the next
// item is taken in the cycle its predecessor's checksum byte is loaded, so
// packets follow one another with no gap on the output. The checksum is
// accumulated byte by byte as the packet is sent. Speed and servo IDs are
// written over the APB port at 0x0, 0x4 and 0x8; the user must write them
// only while the block is idle, as the block itself does not enforce it.
module servo_sync_write_framer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [11:0] horizontal_position, [23:12] vertical_position
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] packet_byte
    output logic             m_tlast,   // last_byte
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [sswf_pkg::SPEED_W-1:0] speed_reg;
    logic [sswf_pkg::ID_W-1:0]    vert_id_reg;
    logic [sswf_pkg::ID_W-1:0]    horz_id_reg;

    // packet sequencing state
    logic                          busy_reg;
    logic [sswf_pkg::IDX_W-1:0]    pos_reg;
    logic [sswf_pkg::POS_W-1:0]    horz_reg;
    logic [sswf_pkg::POS_W-1:0]    vert_reg;
    logic [sswf_pkg::BYTE_W-1:0]   sum_reg;
    logic [sswf_pkg::BYTE_W-1:0]   sum_next;

    // output register
    logic                          out_valid_reg;
    logic [sswf_pkg::BYTE_W-1:0]   out_data_reg;
    logic                          out_last_reg;

    logic                          cfg_write;
    logic                          out_load;
    logic                          emit;
    logic                          at_end;
    logic                          in_xfer;
    logic [sswf_pkg::BYTE_W-1:0]   cur_byte;
    logic                          in_sum_range;

    // apb write and read
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= sswf_pkg::SPEED_RESET;
            vert_id_reg <= sswf_pkg::VERT_ID_RESET;
            horz_id_reg <= sswf_pkg::HORZ_ID_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                sswf_pkg::REG_MOVE_SPEED: speed_reg   <= pwdata[sswf_pkg::SPEED_W-1:0];
                sswf_pkg::REG_VERT_ID:    vert_id_reg <= pwdata[sswf_pkg::ID_W-1:0];
                sswf_pkg::REG_HORZ_ID:    horz_id_reg <= pwdata[sswf_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sswf_pkg::REG_MOVE_SPEED: prdata = {21'd0, speed_reg};
            sswf_pkg::REG_VERT_ID:    prdata = {24'd0, vert_id_reg};
            sswf_pkg::REG_HORZ_ID:    prdata = {24'd0, horz_id_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // handshake control
    assign out_load = !out_valid_reg || m_tready;
    assign emit     = busy_reg && out_load;
    assign at_end   = (pos_reg == sswf_pkg::BYTE_CHECKSUM);
    assign s_tready = !busy_reg || (emit && at_end);
    assign in_xfer  = s_tvalid && s_tready;

    // current packet byte
    always_comb begin
        unique case (pos_reg) inside
            sswf_pkg::BYTE_HDR0, sswf_pkg::BYTE_HDR1:
                cur_byte = sswf_pkg::HDR_BYTE;
            sswf_pkg::BYTE_BCAST:      cur_byte = sswf_pkg::BCAST_ID;
            sswf_pkg::BYTE_LENGTH:     cur_byte = sswf_pkg::LENGTH_FIELD;
            sswf_pkg::BYTE_INSTR:      cur_byte = sswf_pkg::INSTR_SYNC_W;
            sswf_pkg::BYTE_ADDR:       cur_byte = sswf_pkg::START_ADDR;
            sswf_pkg::BYTE_DLEN:       cur_byte = sswf_pkg::DATA_LEN;
            sswf_pkg::BYTE_VERT_ID:    cur_byte = vert_id_reg;
            sswf_pkg::BYTE_VERT_LO:    cur_byte = vert_reg[7:0];
            sswf_pkg::BYTE_VERT_HI:    cur_byte = {4'd0, vert_reg[11:8]};
            sswf_pkg::BYTE_HORZ_ID:    cur_byte = horz_id_reg;
            sswf_pkg::BYTE_HORZ_LO:    cur_byte = horz_reg[7:0];
            sswf_pkg::BYTE_HORZ_HI:    cur_byte = {4'd0, horz_reg[11:8]};
            sswf_pkg::BYTE_VERT_SPDLO, sswf_pkg::BYTE_HORZ_SPDLO:
                cur_byte = speed_reg[7:0];
            sswf_pkg::BYTE_VERT_SPDHI, sswf_pkg::BYTE_HORZ_SPDHI:
                cur_byte = {5'd0, speed_reg[10:8]};
            sswf_pkg::BYTE_CHECKSUM:   cur_byte = ~sum_reg;
            default:                   cur_byte = '0;
        endcase
    end

    // running checksum over bytes 2..16
    assign in_sum_range = (pos_reg >= sswf_pkg::BYTE_BCAST) &&
                          (pos_reg <= sswf_pkg::BYTE_HORZ_SPDHI);
    assign sum_next     = in_sum_range ? sum_reg + cur_byte : sum_reg;

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
            sum_reg  <= '0;
        end else if (in_xfer) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
            sum_reg  <= '0;
        end else if (emit) begin
            if (at_end) begin
                busy_reg <= 1'b0;
                pos_reg  <= '0;
            end else begin
                pos_reg  <= pos_reg + 5'd1;
            end
            sum_reg <= sum_next;
        end
    end

    // held positions
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            horz_reg <= s_tdata[11:0];
            vert_reg <= s_tdata[23:12];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= cur_byte;
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ src/sswf_checker.sv @@
// sswf_checker: port-level assertions for servo_sync_write_framer_unit
// bound to the top level; depends on sswf_pkg
`default_nettype none

module sswf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // a stalled output transfer holds its payload
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("output changed while stalled");

    // reset empties the output register
    property p_reset_clear;
        @(posedge aclk) !aresetn |=> !m_tvalid;
    endproperty
    a_reset_clear: assert property (p_reset_clear) else $error("output valid after reset");

    // an accepted item keeps the input closed while its packet is sent
    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input ready right after accepting an item");

    // a byte that follows a packet end is a header byte
    property p_header_after_last;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata == sswf_pkg::HDR_BYTE;
    endproperty
    a_header_after_last: assert property (p_header_after_last)
        else $error("packet does not start with a header byte");

endmodule

bind servo_sync_write_framer_unit sswf_checker u_sswf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
